// ----- src/wes_pkg.sv -----
// ----------------------------------------------------------------------------
// wes_pkg
// Shared types and constants for the wave-equation stencil stream.
// ----------------------------------------------------------------------------
package wes_pkg;

    localparam int DATA_W     = 24;
    localparam int SIDE_W     = 9;
    localparam int R2_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_BITS  = 16;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(256);
    localparam logic [R2_W-1:0]   R2_RESET   = R2_W'(14272);

    typedef logic signed [DATA_W-1:0] t_data;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_INTERIOR_SIDE = 1'b0,
        CFG_R_SQUARED     = 1'b1
    } t_cfg_idx;

    // Registered read data of the line buffers for one grid point.
    typedef struct packed {
        t_data above;
        t_data center;
        t_data east;
        t_data prev;
    } t_lb_rd;

endpackage

// ----- src/wes_if.sv -----
// ----------------------------------------------------------------------------
// wes_if
// Valid/ready channels of the stencil stream: input points, results, config.
// ----------------------------------------------------------------------------
interface wes_in_if;
    logic          valid;
    logic          ready;
    wes_pkg::t_data u_now;
    wes_pkg::t_data u_prev;

    modport source (output valid, output u_now, output u_prev, input ready);
    modport sink   (input valid, input u_now, input u_prev, output ready);
endinterface

interface wes_out_if;
    logic          valid;
    logic          ready;
    wes_pkg::t_data u_next;
    logic          frame_last;

    modport source (output valid, output u_next, output frame_last, input ready);
    modport sink   (input valid, input u_next, input frame_last, output ready);
endinterface

interface wes_cfg_if;
    logic                                valid;
    logic                                ready;
    wes_pkg::t_cfg_idx                   index;
    logic [wes_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/wes_linebuf.sv -----
// ----------------------------------------------------------------------------
// wes_linebuf
// Row buffers for the current field (row above, center row) and the previous
// step, with registered reads at the point's column and the column east of it.
// ----------------------------------------------------------------------------
module wes_linebuf #(
    parameter int DEPTH = 258,
    parameter int AW    = 9
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  wes_pkg::t_data      i_wr_now,
    input  wes_pkg::t_data      i_wr_prev,
    output wes_pkg::t_lb_rd     o_rd
);
    import wes_pkg::*;

    t_data mem_above  [DEPTH];
    t_data mem_center [DEPTH];
    t_data mem_prev   [DEPTH];

    t_lb_rd        r_rd;
    logic [AW-1:0] east_addr;

    // The east read of the last padded column is never used; keep it in range.
    assign east_addr = (i_rd_addr == AW'(DEPTH - 1)) ? '0 : i_rd_addr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd.above  <= mem_above[i_rd_addr];
            r_rd.center <= mem_center[i_rd_addr];
            r_rd.east   <= mem_center[east_addr];
            r_rd.prev   <= mem_prev[i_rd_addr];
        end
    end

    // The old center value moves down into the row-above buffer.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_above[i_wr_addr]  <= r_rd.center;
            mem_center[i_wr_addr] <= i_wr_now;
            mem_prev[i_wr_addr]   <= i_wr_prev;
        end
    end

    assign o_rd = r_rd;

endmodule

// ----- src/wes_stencil.sv -----
// ----------------------------------------------------------------------------
// wes_stencil
// Five-point leapfrog update: 2c - p + ((r2 * (n + s + e + w - 4c)) >>> 16),
// saturated to the signed data width.
// ----------------------------------------------------------------------------
module wes_stencil (
    input  wes_pkg::t_data             i_center,
    input  wes_pkg::t_data             i_north,
    input  wes_pkg::t_data             i_south,
    input  wes_pkg::t_data             i_east,
    input  wes_pkg::t_data             i_west,
    input  wes_pkg::t_data             i_prev,
    input  logic [wes_pkg::R2_W-1:0]   i_r2,
    output wes_pkg::t_data             o_next
);
    import wes_pkg::*;

    localparam int LAP_W  = DATA_W + 3;
    localparam int PROD_W = LAP_W + R2_W + 1;
    localparam int SCL_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = SCL_W + 1;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (DATA_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (DATA_W - 1));

    logic signed [LAP_W-1:0]  lap;
    logic signed [PROD_W-1:0] prod;
    logic signed [SCL_W-1:0]  scaled;
    logic signed [SUM_W-1:0]  total;

    assign lap = LAP_W'(i_north) + LAP_W'(i_south) + LAP_W'(i_east) + LAP_W'(i_west)
               - (LAP_W'(i_center) <<< 2);
    assign prod   = PROD_W'(lap) * PROD_W'($signed({1'b0, i_r2}));
    assign scaled = SCL_W'(prod >>> FRAC_BITS);
    assign total  = (SUM_W'(i_center) <<< 1) - SUM_W'(i_prev) + SUM_W'(scaled);

    always_comb begin
        if (total > SAT_MAX) begin
            o_next = t_data'(SAT_MAX);
        end else if (total < SAT_MIN) begin
            o_next = t_data'(SAT_MIN);
        end else begin
            o_next = t_data'(total);
        end
    end

endmodule

// ----- src/wave_equation_stencil_stream.sv -----
// ----------------------------------------------------------------------------
// wave_equation_stencil_stream
// One time step of the 2D wave equation over a streamed, padded grid.
// ----------------------------------------------------------------------------
// Usage: the padded grid of (side+2) x (side+2) points enters on i_in in
// raster order, one word per point carrying u_now and u_prev. For each
// interior point one word leaves on o_out when the point below it arrives;
// frame_last marks the final interior point of the grid. Border points and
// the first two rows produce no word.
// A word passes the line-buffer read register and stage 1, then the result
// register, on its way to o_out. Throughput is one word per cycle while
// o_out is not stalled: the line buffers take one registered read (two
// columns of the center row) and one write per cycle, and a point's write
// never meets a read of the same column in that cycle, so nothing else
// limits the rate.
// Configuration (i_cfg) is always ready: index 0 sets the interior side,
// index 1 sets r_squared. Write it only while the stream is idle.
// Reset clears the row/column position and the pipeline; the line buffers are
// not cleared. When o_out stalls, words enter the stage before the result register
// until one that yields a word waits there; then i_in.ready drops until o_out drains.
// ----------------------------------------------------------------------------
module wave_equation_stencil_stream #(
    parameter int MAX_SIDE = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wes_in_if.sink     i_in,
    wes_out_if.source  o_out,
    wes_cfg_if.sink    i_cfg
);
    import wes_pkg::*;

    localparam int DEPTH = MAX_SIDE + 2;
    localparam int CW    = $clog2(DEPTH);

    // Configuration registers.
    logic [SIDE_W-1:0] r_side;
    logic [R2_W-1:0]   r_r2;

    // Grid position of the next input word.
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;

    // Stage 1: point waiting on its line-buffer read data.
    logic          r_s1_vld;
    t_data         r_s1_now;
    t_data         r_s1_prev;
    logic [CW-1:0] r_s1_col;
    logic          r_s1_emit;
    logic          r_s1_flast;
    logic          r_s1_lastcol;
    t_data         r_west;

    // Result register.
    logic  r_out_vld;
    t_data r_out_data;
    logic  r_out_flast;

    logic [CW-1:0] side_eff, last, rr, cc;
    logic          emit, flast, lastcol;
    logic          in_acc, out_free, s1_adv;
    t_lb_rd        lb_rd;
    t_data         next_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RESET;
            r_r2   <= R2_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_INTERIOR_SIDE: r_side <= i_cfg.data[SIDE_W-1:0];
                CFG_R_SQUARED:     r_r2   <= i_cfg.data[R2_W-1:0];
                default:           ;
            endcase
        end
    end
    assign i_cfg.ready = 1'b1;

    // Effective side: zero acts as one, anything above MAX_SIDE as MAX_SIDE.
    always_comb begin
        if (r_side == '0) begin
            side_eff = CW'(1);
        end else if (32'(r_side) > MAX_SIDE) begin
            side_eff = CW'(MAX_SIDE);
        end else begin
            side_eff = CW'(r_side);
        end
    end

    assign last    = side_eff + 1'b1;
    assign rr      = (r_row > last) ? last : r_row;
    assign cc      = (r_col > last) ? last : r_col;
    assign emit    = (rr >= CW'(2)) && (cc >= CW'(1)) && (cc <= side_eff);
    assign flast   = (rr == last) && (cc == side_eff);
    assign lastcol = (cc >= last);

    always_comb begin
        if (lastcol) begin
            n_col = '0;
            n_row = (rr >= last) ? '0 : rr + 1'b1;
        end else begin
            n_col = cc + 1'b1;
            n_row = rr;
        end
    end

    assign out_free   = !r_out_vld || o_out.ready;
    assign s1_adv     = r_s1_vld && (!r_s1_emit || out_free);
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_west   <= '0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            // The west neighbor is the previous point's old center, zero at row start.
            if (s1_adv) begin
                r_west <= r_s1_lastcol ? '0 : lb_rd.center;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_now     <= i_in.u_now;
            r_s1_prev    <= i_in.u_prev;
            r_s1_col     <= cc;
            r_s1_emit    <= emit;
            r_s1_flast   <= flast;
            r_s1_lastcol <= lastcol;
        end
    end

    wes_linebuf #(
        .DEPTH (DEPTH),
        .AW    (CW)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (cc),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_now  (r_s1_now),
        .i_wr_prev (r_s1_prev),
        .o_rd      (lb_rd)
    );

    wes_stencil u_stencil (
        .i_center (lb_rd.center),
        .i_north  (lb_rd.above),
        .i_south  (r_s1_now),
        .i_east   (lb_rd.east),
        .i_west   (r_west),
        .i_prev   (lb_rd.prev),
        .i_r2     (r_r2),
        .o_next   (next_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv && r_s1_emit) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_out_data  <= next_val;
            r_out_flast <= r_s1_flast;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.u_next     = r_out_data;
    assign o_out.frame_last = r_out_flast;

endmodule

// ----- src/wes_check.sv -----
// ----------------------------------------------------------------------------
// wes_check
// Port-level checks of the stencil stream, bound to the top level.
// ----------------------------------------------------------------------------
module wes_check (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input wes_pkg::t_data i_out_u_next,
    input logic           i_out_frame_last,
    input logic           i_cfg_ready
);
    import wes_pkg::*;

    // The pipeline is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_u_next) && $stable(i_out_frame_last))
        else $error("stalled result changed");

    // With the receiver ready, the block never backpressures its source.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output is ready");

    // A word taken from the input never holds up the next one by more than
    // the single stage in front of the result register.
    a_in_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input not ready without an output stall");

    // The configuration port takes a write in every cycle.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind wave_equation_stencil_stream wes_check u_wes_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_u_next     (o_out.u_next),
    .i_out_frame_last (o_out.frame_last),
    .i_cfg_ready      (i_cfg.ready)
);
